[src/fabm_pkg.sv]
package fabm_pkg;

   // Default number of physical frames held in the used map.
   localparam int unsigned NUM_FRAMES_DEF = 4096;

   // Frames that the page frame field can name.
   localparam int unsigned PAGE_FIELD_FRAMES = 4096;

   // Bits in one word of the used map.
   localparam int unsigned WORD_BITS = 32;

   // Request modes.
   localparam logic [1:0] MODE_ALLOC = 2'd0;
   localparam logic [1:0] MODE_FREE  = 2'd1;
   localparam logic [1:0] MODE_MARK  = 2'd2;
   localparam logic [1:0] MODE_TEST  = 2'd3;

   // Response status codes.
   localparam logic [2:0] STATUS_DONE      = 3'd0;
   localparam logic [2:0] STATUS_HAS_FRAME = 3'd1;
   localparam logic [2:0] STATUS_NO_FREE   = 3'd2;
   localparam logic [2:0] STATUS_NO_FRAME  = 3'd3;
   localparam logic [2:0] STATUS_RANGE     = 3'd4;

   // One-hot mask of the lowest clear bit of a map word.
   function automatic logic [WORD_BITS-1:0] lowest_clear(input logic [WORD_BITS-1:0] w);
      lowest_clear = ~w & (w + WORD_BITS'(1));
   endfunction

   // Bit position of a one-hot mask.
   function automatic logic [4:0] onehot_index(input logic [WORD_BITS-1:0] oh);
      logic [4:0] idx;
      idx = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (oh[i]) begin
            idx = idx | 5'(i);
         end
      end
      onehot_index = idx;
   endfunction

endpackage

[src/frame_bitmap_allocator_core.sv]
// Allocate scans from map word 0 up to the frame limit, then sets the bit that it finds;
// the scan reads and checks one map word a cycle through the one RAM.
// Free, mark and test read the word, then modify and write it; rejected requests only reply.
// One request is in progress at a time; a response waits in an output register, and the
// next request is taken from the cycle after the response is loaded.
// After reset a clearing pass writes zero to every map word, during which no request is
// taken; configuration writes are taken at any time.
module frame_bitmap_allocator_core #(
   parameter int unsigned NUM_FRAMES = fabm_pkg::NUM_FRAMES_DEF
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        csr_wr_en,
   input  logic [12:0] csr_wr_data,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [31:0] req_frame_address,
   input  logic [11:0] req_page_frame,
   input  logic        req_want_user,
   input  logic        req_want_writable,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [11:0] rsp_new_page_frame,
   output logic        rsp_page_present,
   output logic        rsp_page_writable,
   output logic        rsp_page_user,
   output logic        rsp_frame_used
);

   localparam int unsigned WB        = fabm_pkg::WORD_BITS;
   localparam int unsigned MAP_WORDS = NUM_FRAMES / WB;
   localparam int unsigned AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int unsigned LIMIT_CAP = (NUM_FRAMES < fabm_pkg::PAGE_FIELD_FRAMES) ?
                                       NUM_FRAMES : fabm_pkg::PAGE_FIELD_FRAMES;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_ALLOC_WR,
      S_READ,
      S_MODIFY,
      S_REPLY
   } state_type;

   state_type   state_ff, state_in;
   logic [12:0] frame_count_ff, frame_count_in;
   logic [AW-1:0] clr_idx_ff, clr_idx_in;

   logic [1:0]  op_ff, op_in;
   logic [11:0] pf_ff, pf_in;
   logic        wu_ff, wu_in;
   logic        ww_ff, ww_in;
   logic [4:0]  bit_ff, bit_in;
   logic [AW-1:0] widx_ff, widx_in;
   logic [2:0]  err_status_ff, err_status_in;

   logic [7:0]  rd_cnt_ff, rd_cnt_in;
   logic        chk_vld_ff, chk_vld_in;
   logic [7:0]  chk_idx_ff, chk_idx_in;
   logic [WB-1:0] word_ff, word_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_status_ff, rsp_status_in;
   logic [11:0] rsp_npf_ff, rsp_npf_in;
   logic        rsp_present_ff, rsp_present_in;
   logic        rsp_writable_ff, rsp_writable_in;
   logic        rsp_user_ff, rsp_user_in;
   logic        rsp_used_ff, rsp_used_in;

   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [WB-1:0] ram_wr_data;
   logic          ram_rd_en;
   logic [AW-1:0] ram_rd_addr;
   logic [WB-1:0] ram_rd_data;

   logic [12:0]   scan_lim;
   logic [7:0]    scan_words;
   logic          out_free;
   logic          accept;
   logic [WB-1:0] alloc_mask;
   logic [WB-1:0] bit_mask;
   logic [14:0]   addr_word;
   logic [14:0]   pf_word;
   logic [14:0]   rd_cnt_word;
   logic [14:0]   chk_word;

   fabm_ram #(
      .WIDTH  (WB),
      .DEPTH  (MAP_WORDS),
      .ADDR_W (AW)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Words that allocate may scan: whole words below the frame limit.
   assign scan_lim   = (frame_count_ff < 13'(LIMIT_CAP)) ? frame_count_ff : 13'(LIMIT_CAP);
   assign scan_words = scan_lim[12:5];

   // Map word indexes of the request fields and of the scan counters.
   assign addr_word   = req_frame_address[31:17];
   assign pf_word     = {8'b0, req_page_frame[11:5]};
   assign rd_cnt_word = {7'b0, rd_cnt_ff};
   assign chk_word    = {7'b0, chk_idx_ff};

   assign alloc_mask = fabm_pkg::lowest_clear(word_ff);
   assign bit_mask   = WB'(1) << bit_ff;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Sequencer: decode, map scan, read-modify-write and response loading.
   always_comb begin
      state_in        = state_ff;
      frame_count_in  = frame_count_ff;
      clr_idx_in      = clr_idx_ff;
      op_in           = op_ff;
      pf_in           = pf_ff;
      wu_in           = wu_ff;
      ww_in           = ww_ff;
      bit_in          = bit_ff;
      widx_in         = widx_ff;
      err_status_in   = err_status_ff;
      rd_cnt_in       = rd_cnt_ff;
      chk_vld_in      = chk_vld_ff;
      chk_idx_in      = chk_idx_ff;
      word_in         = word_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_status_in   = rsp_status_ff;
      rsp_npf_in      = rsp_npf_ff;
      rsp_present_in  = rsp_present_ff;
      rsp_writable_in = rsp_writable_ff;
      rsp_user_in     = rsp_user_ff;
      rsp_used_in     = rsp_used_ff;
      ram_wr_en       = 1'b0;
      ram_wr_addr     = widx_ff;
      ram_wr_data     = '0;
      ram_rd_en       = 1'b0;
      ram_rd_addr     = widx_ff;

      // The frame limit register is written whenever the port asks.
      if (csr_wr_en) begin
         frame_count_in = csr_wr_data;
      end

      case (state_ff)
         S_CLEAR: begin
            // Clearing pass: one map word a cycle.
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_idx_ff;
            ram_wr_data = '0;
            clr_idx_in  = clr_idx_ff + AW'(1);
            if (clr_idx_ff == AW'(MAP_WORDS - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (accept) begin
               op_in      = req_mode;
               pf_in      = req_page_frame;
               wu_in      = req_want_user;
               ww_in      = req_want_writable;
               rd_cnt_in  = '0;
               chk_vld_in = 1'b0;
               case (req_mode)
                  fabm_pkg::MODE_ALLOC: begin
                     if (req_page_frame != 12'd0) begin
                        err_status_in = fabm_pkg::STATUS_HAS_FRAME;
                        state_in      = S_REPLY;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  fabm_pkg::MODE_FREE: begin
                     widx_in = pf_word[AW-1:0];
                     bit_in  = req_page_frame[4:0];
                     if (req_page_frame == 12'd0) begin
                        err_status_in = fabm_pkg::STATUS_NO_FRAME;
                        state_in      = S_REPLY;
                     end else if ({20'b0, req_page_frame} >= 32'(NUM_FRAMES)) begin
                        err_status_in = fabm_pkg::STATUS_RANGE;
                        state_in      = S_REPLY;
                     end else begin
                        state_in = S_READ;
                     end
                  end
                  default: begin
                     widx_in = addr_word[AW-1:0];
                     bit_in  = req_frame_address[16:12];
                     if ({12'b0, req_frame_address[31:12]} >= 32'(NUM_FRAMES)) begin
                        err_status_in = fabm_pkg::STATUS_RANGE;
                        state_in      = S_REPLY;
                     end else begin
                        state_in = S_READ;
                     end
                  end
               endcase
            end
         end

         S_SCAN: begin
            // Read one word a cycle; the word read last cycle is checked now.
            if (chk_vld_ff && (ram_rd_data != '1)) begin
               word_in  = ram_rd_data;
               state_in = S_ALLOC_WR;
            end else if (rd_cnt_ff >= scan_words) begin
               chk_vld_in = 1'b0;
               if (!chk_vld_ff) begin
                  err_status_in = fabm_pkg::STATUS_NO_FREE;
                  state_in      = S_REPLY;
               end
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = rd_cnt_word[AW-1:0];
               chk_vld_in  = 1'b1;
               chk_idx_in  = rd_cnt_ff;
               rd_cnt_in   = rd_cnt_ff + 8'd1;
            end
         end

         S_ALLOC_WR: begin
            // Set the lowest clear bit of the found word and hand out its frame.
            if (out_free) begin
               ram_wr_en       = 1'b1;
               ram_wr_addr     = chk_word[AW-1:0];
               ram_wr_data     = word_ff | alloc_mask;
               rsp_valid_in    = 1'b1;
               rsp_status_in   = fabm_pkg::STATUS_DONE;
               rsp_npf_in      = {chk_idx_ff[6:0], fabm_pkg::onehot_index(alloc_mask)};
               rsp_present_in  = 1'b1;
               rsp_writable_in = ww_ff;
               rsp_user_in     = wu_ff;
               rsp_used_in     = 1'b0;
               state_in        = S_IDLE;
            end
         end

         S_READ: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = widx_ff;
            state_in    = S_MODIFY;
         end

         S_MODIFY: begin
            // Update or report the addressed bit once the output register is free.
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_status_in   = fabm_pkg::STATUS_DONE;
               rsp_npf_in      = pf_ff;
               rsp_present_in  = 1'b0;
               rsp_writable_in = 1'b0;
               rsp_user_in     = 1'b0;
               rsp_used_in     = 1'b0;
               ram_wr_addr     = widx_ff;
               case (op_ff)
                  fabm_pkg::MODE_FREE: begin
                     ram_wr_en   = 1'b1;
                     ram_wr_data = ram_rd_data & ~bit_mask;
                     rsp_npf_in  = 12'd0;
                  end
                  fabm_pkg::MODE_MARK: begin
                     ram_wr_en   = 1'b1;
                     ram_wr_data = ram_rd_data | bit_mask;
                  end
                  default: begin
                     rsp_used_in = ram_rd_data[bit_ff];
                  end
               endcase
               state_in = S_IDLE;
            end
         end

         S_REPLY: begin
            // Rejected request: status only, page frame unchanged.
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_status_in   = err_status_ff;
               rsp_npf_in      = pf_ff;
               rsp_present_in  = 1'b0;
               rsp_writable_in = 1'b0;
               rsp_user_in     = 1'b0;
               rsp_used_in     = 1'b0;
               state_in        = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         frame_count_ff <= 13'd4096;
         clr_idx_ff     <= '0;
         chk_vld_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         frame_count_ff <= frame_count_in;
         clr_idx_ff     <= clr_idx_in;
         chk_vld_ff     <= chk_vld_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      op_ff           <= op_in;
      pf_ff           <= pf_in;
      wu_ff           <= wu_in;
      ww_ff           <= ww_in;
      bit_ff          <= bit_in;
      widx_ff         <= widx_in;
      err_status_ff   <= err_status_in;
      rd_cnt_ff       <= rd_cnt_in;
      chk_idx_ff      <= chk_idx_in;
      word_ff         <= word_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_npf_ff      <= rsp_npf_in;
      rsp_present_ff  <= rsp_present_in;
      rsp_writable_ff <= rsp_writable_in;
      rsp_user_ff     <= rsp_user_in;
      rsp_used_ff     <= rsp_used_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_new_page_frame = rsp_npf_ff;
   assign rsp_page_present   = rsp_present_ff;
   assign rsp_page_writable  = rsp_writable_ff;
   assign rsp_page_user      = rsp_user_ff;
   assign rsp_frame_used     = rsp_used_ff;

endmodule

[src/fabm_ram.sv]
module fabm_ram #(
   parameter int unsigned WIDTH  = 32,
   parameter int unsigned DEPTH  = 128,
   parameter int unsigned ADDR_W = 7
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port; read data holds between reads.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
